// ===== rtl/rgbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_pkg: shared types and constants of the RGB 3x3 convolution filter
// Word layouts of both stream channels, pixel and window types, register
// indexes, register reset values and the kernel selection group.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    // Default frame size limits, handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 36;
    localparam int SIZE_REG_W  = 12;
    localparam int COEF_W      = 12;
    localparam int POS_W       = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COEF_TOP    = 3'd0,
        CFG_COEF_MIDDLE = 3'd1,
        CFG_COEF_BOTTOM = 3'd2,
        CFG_FRAME_WIDTH = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } cfg_index_t;

    // Register reset values: identity kernel, VGA frame
    localparam logic [CFG_DATA_W-1:0] COEF_TOP_RST    = 36'h0_0000_0000;
    localparam logic [CFG_DATA_W-1:0] COEF_MIDDLE_RST = 36'h0_0010_0000;
    localparam logic [CFG_DATA_W-1:0] COEF_BOTTOM_RST = 36'h0_0000_0000;
    localparam logic [SIZE_REG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [SIZE_REG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Input word
    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } pixel_in_t;

    // Output word
    typedef struct packed {
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_column;
        logic             frame_done;
    } pixel_out_t;

    // Internal pixel: channel 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] rgb_t;

    // 3x3 window indexed [row][column], column 2 newest, row 2 current line
    typedef rgb_t [2:0][2:0] window_t;

    // Which border variant of the kernel to apply
    typedef struct packed {
        logic bottom;       // reflect rows below the last row
        logic right;        // reflect columns past the last column
        logic mirror_left;  // reflect the column left of column 0
    } kernel_sel_t;

endpackage : rgbc_pkg
`default_nettype wire

// ===== rtl/rgbc_kernel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_kernel: 3x3 weighted sum of one window, per channel
// Picks the window taps for the requested border variant, multiplies by the
// signed Q4.8 weights, floors the sum and clamps it to 0..255.
// ----------------------------------------------------------------------------
module rgbc_kernel (
    input  var rgbc_pkg::window_t     win,
    input  var logic [35:0]           coef_top,
    input  var logic [35:0]           coef_middle,
    input  var logic [35:0]           coef_bottom,
    input  var rgbc_pkg::kernel_sel_t sel,
    output rgbc_pkg::rgb_t            result
);
    import rgbc_pkg::*;

    logic [2:0][CFG_DATA_W-1:0] coef_rows;
    logic [2:0][1:0]            row_pick;
    logic [2:0][1:0]            col_pick;
    logic signed [23:0]         acc [3];

    assign coef_rows = {coef_bottom, coef_middle, coef_top};

    // Map kernel taps to window positions, reflecting across the border
    always_comb
    begin
        row_pick[0] = sel.bottom ? 2'd1 : 2'd0;
        row_pick[1] = sel.bottom ? 2'd2 : 2'd1;
        row_pick[2] = sel.bottom ? 2'd1 : 2'd2;
        if (sel.right)
        begin
            col_pick[0] = 2'd1;
            col_pick[1] = 2'd2;
            col_pick[2] = 2'd1;
        end
        else
        begin
            col_pick[0] = sel.mirror_left ? 2'd2 : 2'd0;
            col_pick[1] = 2'd1;
            col_pick[2] = 2'd2;
        end
    end

    // Multiply and accumulate the nine taps of each channel
    always_comb
    begin
        logic signed [COEF_W-1:0] wt;
        logic signed [8:0]        px;
        logic signed [20:0]       prod;
        wt   = '0;
        px   = '0;
        prod = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc[ch] = '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    wt   = coef_rows[i][COEF_W*j +: COEF_W];
                    px   = $signed({1'b0, win[row_pick[i]][col_pick[j]][ch]});
                    prod = wt * px;
                    acc[ch] = acc[ch] + {{3{prod[20]}}, prod};
                end
            end
        end
    end

    // Floor to integer and clamp to 0..255
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (acc[ch][23])
                result[ch] = 8'd0;
            else if (|acc[ch][22:16])
                result[ch] = 8'd255;
            else
                result[ch] = acc[ch][15:8];
        end
    end

endmodule : rgbc_kernel
`default_nettype wire

// ===== rtl/rgb_conv3x3_reflect_border.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_conv3x3_reflect_border: RGB 3x3 convolution with reflect-101 borders
// Streams RGB pixels of a frame in raster order and returns each filtered
// pixel with its row, column and a last-of-frame flag.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carry one raster-order pixel word; out_valid/out_ready
//    carry one filtered pixel word. A word moves when valid and ready are high.
//  - cfg_write/cfg_index/cfg_data write the kernel rows and frame size; write
//    them only while the stream is idle.
//  - Output pixel (r,c) leaves once input (r+1,c+1) has been taken. Inputs on
//    row 0 or column 0 yield nothing; on the last row or column one input
//    yields two words, at the last pixel of the frame four.
//  - Pipeline: an input passes the input stage and the window stage, and its
//    words leave through the output register. Throughput is one word per
//    cycle while the receiver is ready, set by the single kernel unit: inputs
//    that release two or four words hold the input side while those go out.
//  - Line stores: two single-port-write memories of MAX_WIDTH x 24 bits with
//    registered reads; they are not cleared, so no clearing pass runs.
//  - Reset clears the counters, the window and the pipeline; the kernel
//    returns to identity and the frame size to 640 x 480.
//  - When the receiver stalls, the output word holds and the pipeline fills;
//    in_ready drops once the input and window stages are both occupied.
// ----------------------------------------------------------------------------
module rgb_conv3x3_reflect_border #(
    parameter int MAX_WIDTH  = rgbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbc_pkg::DEF_MAX_HEIGHT
) (
    input  var logic                                 clk,
    input  var logic                                 rst_n,
    input  var logic                                 in_valid,
    output logic                                     in_ready,
    input  var rgbc_pkg::pixel_in_t                  in_data,
    output logic                                     out_valid,
    input  var logic                                 out_ready,
    output rgbc_pkg::pixel_out_t                     out_data,
    input  var logic                                 cfg_write,
    input  var logic [rgbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  var logic [rgbc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rgbc_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int MW   = (CW > RW) ? CW : RW;
    localparam int SZW  = (MW + 1 > SIZE_REG_W) ? MW + 1 : SIZE_REG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] coef_top_reg, coef_middle_reg, coef_bottom_reg;
    logic [SIZE_REG_W-1:0] frame_width_reg, frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg     <= COEF_TOP_RST;
            coef_middle_reg  <= COEF_MIDDLE_RST;
            coef_bottom_reg  <= COEF_BOTTOM_RST;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COEF_TOP:     coef_top_reg     <= cfg_data;
                CFG_COEF_MIDDLE:  coef_middle_reg  <= cfg_data;
                CFG_COEF_BOTTOM:  coef_bottom_reg  <= cfg_data;
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIZE_REG_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame size into 2..MAX
    logic [SZW-1:0] width_raw, height_raw, eff_width, eff_height;

    assign width_raw  = SZW'(frame_width_reg);
    assign height_raw = SZW'(frame_height_reg);

    always_comb
    begin
        if (width_raw < SZW'(2))
            eff_width = SZW'(2);
        else if (width_raw > SZW'(MAX_WIDTH))
            eff_width = SZW'(MAX_WIDTH);
        else
            eff_width = width_raw;

        if (height_raw < SZW'(2))
            eff_height = SZW'(2);
        else if (height_raw > SZW'(MAX_HEIGHT))
            eff_height = SZW'(MAX_HEIGHT);
        else
            eff_height = height_raw;
    end

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic          in_accept;
    logic [RW-1:0] row_cnt_reg, row_cnt_next, cur_row;
    logic [CW-1:0] col_cnt_reg, col_cnt_next, cur_col;
    logic          out_of_frame, cur_last_row, cur_last_col;
    rgb_t          in_pixel;

    assign in_accept = in_valid && in_ready;
    assign in_pixel  = {in_data.pixel_blue, in_data.pixel_green, in_data.pixel_red};

    // Restart at the origin if the position lies outside the frame
    assign out_of_frame = (SZW'(row_cnt_reg) >= eff_height) ||
                          (SZW'(col_cnt_reg) >= eff_width);
    assign cur_row      = out_of_frame ? '0 : row_cnt_reg;
    assign cur_col      = out_of_frame ? '0 : col_cnt_reg;
    assign cur_last_row = (SZW'(cur_row) == eff_height - SZW'(1));
    assign cur_last_col = (SZW'(cur_col) == eff_width - SZW'(1));

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (in_accept)
        begin
            if (cur_last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = cur_last_row ? '0 : cur_row + RW'(1);
            end
            else
            begin
                row_cnt_next = cur_row;
                col_cnt_next = cur_col + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: pixel, position and line store reads
    // ------------------------------------------------------------------
    logic          s1_valid_reg, s1_valid_next;
    rgb_t          s1_pixel_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_last_row_reg, s1_last_col_reg;
    logic          w_take;

    assign in_ready      = !s1_valid_reg || w_take;
    assign s1_valid_next = in_accept ? 1'b1 : (w_take ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Hold the pixel and its position while the window stage is busy
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg    <= in_pixel;
            s1_row_reg      <= cur_row;
            s1_col_reg      <= cur_col;
            s1_last_row_reg <= cur_last_row;
            s1_last_col_reg <= cur_last_col;
        end
    end

    // Line stores: row above and two rows above, registered reads
    rgb_t line_prev_mem  [MAX_WIDTH];
    rgb_t line_prev2_mem [MAX_WIDTH];
    rgb_t line_prev_rd_reg, line_prev2_rd_reg;

    // Read the row above, then overwrite it with the new pixel
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_prev_rd_reg     <= line_prev_mem[cur_col];
            line_prev_mem[cur_col] <= in_pixel;
        end
    end

    // Shift the row above down once its read data is in hand
    always_ff @(posedge clk)
    begin
        if (in_accept)
            line_prev2_rd_reg <= line_prev2_mem[cur_col];
        if (w_take)
            line_prev2_mem[s1_col_reg] <= line_prev_rd_reg;
    end

    // ------------------------------------------------------------------
    // Window stage: 3x3 window and pending output words
    // ------------------------------------------------------------------
    window_t       win_reg, win_next;
    logic [3:0]    w_mask_reg, w_mask_next;   // main, bottom, right, corner
    logic [RW-1:0] w_row_reg;
    logic [CW-1:0] w_col_reg;
    logic          w_col_one_reg;
    logic [3:0]    w_first;
    logic          w_single;
    logic          out_free, emit_fire;
    rgb_t          new_top;
    logic          s1_emits;

    assign out_free  = !out_valid || out_ready;
    assign emit_fire = (|w_mask_reg) && out_free;
    assign w_first   = w_mask_reg & (~w_mask_reg + 4'd1);
    assign w_single  = ((w_mask_reg & (w_mask_reg - 4'd1)) == 4'd0);
    assign w_take    = s1_valid_reg && ((w_mask_reg == 4'd0) || (emit_fire && w_single));
    assign new_top   = (s1_row_reg == RW'(1)) ? s1_pixel_reg : line_prev2_rd_reg;
    assign s1_emits  = (s1_row_reg != '0) && (s1_col_reg != '0);

    // Shift the window on take, drop one pending word per emit
    always_comb
    begin
        win_next    = win_reg;
        w_mask_next = w_mask_reg;
        if (w_take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = new_top;
            win_next[1][2] = line_prev_rd_reg;
            win_next[2][2] = s1_pixel_reg;
            w_mask_next = s1_emits ? {s1_last_row_reg && s1_last_col_reg,
                                      s1_last_col_reg, s1_last_row_reg, 1'b1}
                                   : 4'd0;
        end
        else if (emit_fire)
        begin
            w_mask_next = w_mask_reg & (w_mask_reg - 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            w_mask_reg <= 4'd0;
        end
        else
        begin
            win_reg    <= win_next;
            w_mask_reg <= w_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_take)
        begin
            w_row_reg     <= s1_row_reg;
            w_col_reg     <= s1_col_reg;
            w_col_one_reg <= (s1_col_reg == CW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Kernel and output register
    // ------------------------------------------------------------------
    kernel_sel_t   sel;
    rgb_t          kernel_rgb;
    logic [RW-1:0] emit_row;
    logic [CW-1:0] emit_col;
    logic          out_valid_reg, out_valid_next;
    pixel_out_t    out_data_reg, out_data_next;

    assign sel.bottom      = w_first[1] || w_first[3];
    assign sel.right       = w_first[2] || w_first[3];
    assign sel.mirror_left = w_col_one_reg;

    rgbc_kernel u_kernel (
        .win         (win_reg),
        .coef_top    (coef_top_reg),
        .coef_middle (coef_middle_reg),
        .coef_bottom (coef_bottom_reg),
        .sel         (sel),
        .result      (kernel_rgb)
    );

    assign emit_row = sel.bottom ? w_row_reg : w_row_reg - RW'(1);
    assign emit_col = sel.right  ? w_col_reg : w_col_reg - CW'(1);

    always_comb
    begin
        out_data_next.out_red    = kernel_rgb[0];
        out_data_next.out_green  = kernel_rgb[1];
        out_data_next.out_blue   = kernel_rgb[2];
        out_data_next.out_row    = POS_W'(emit_row);
        out_data_next.out_column = POS_W'(emit_col);
        out_data_next.frame_done = w_first[3];
    end

    assign out_valid_next = emit_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // More than one pending word with a waiting input keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && ($countones(w_mask_reg) > 1)) |-> !in_ready)
    else $error("input taken while window stage still owes several words");

    // With the main word pending, a corner word comes with its bottom and right words
    assert property (@(posedge clk) disable iff (!rst_n)
        (w_mask_reg[3] && w_mask_reg[0]) |-> (w_mask_reg[1] && w_mask_reg[2]))
    else $error("corner word pending without its border words");

    // Pixels on the first row release no word
    assert property (@(posedge clk) disable iff (!rst_n)
        (w_take && (s1_row_reg == '0)) |=> (w_mask_reg == 4'd0))
    else $error("first-row pixel released an output word");

    // An emitted word is on the output in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid_reg)
    else $error("emitted word lost before the output register");

    // frame_done only on the last column of the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && w_first[3]) |->
            ((SZW'(w_row_reg) == eff_height - SZW'(1)) &&
             (SZW'(w_col_reg) == eff_width - SZW'(1))))
    else $error("frame_done raised away from the last pixel");

endmodule : rgb_conv3x3_reflect_border
`default_nettype wire
